@@ sv/utf8d_pkg.sv @@
// Shared types, constants and helper functions of the UTF-8 decoder.
`default_nettype none
package utf8d_pkg;

    localparam int unsigned CP_W       = 21;
    localparam int unsigned CNT_W      = 16;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned Q_DEPTH    = 4;
    localparam int unsigned Q_PTR_W    = 2;
    localparam int unsigned Q_CNT_W    = 3;

    localparam logic [CP_W-1:0] SUB_CHAR     = 21'd63;
    localparam logic [CP_W-1:0] SURR_D800    = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_DB7F    = 21'h00DB7F;
    localparam logic [CP_W-1:0] SURR_DB80    = 21'h00DB80;
    localparam logic [CP_W-1:0] SURR_DBFF    = 21'h00DBFF;
    localparam logic [CP_W-1:0] SURR_DC00    = 21'h00DC00;
    localparam logic [CP_W-1:0] SURR_DF80    = 21'h00DF80;
    localparam logic [CP_W-1:0] SURR_DFFF    = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_TWO      = 21'h000080;
    localparam logic [CP_W-1:0] MAX_TWO      = 21'h0007FF;
    localparam logic [CP_W-1:0] MIN_THREE    = 21'h000800;
    localparam logic [CP_W-1:0] MAX_THREE    = 21'h00FFFD;
    localparam logic [CP_W-1:0] MAX_BMP      = 21'h00FFFF;
    localparam logic [CP_W-1:0] MIN_FOUR     = 21'h010000;
    localparam logic [CP_W-1:0] MAX_FOUR     = 21'h10FFFF;

    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;
    localparam logic [2:0] LEN_FIVE  = 3'd5;
    localparam logic [2:0] LEN_SIX   = 3'd6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UCS2_MODE = 1'b0,
        CFG_MAX_CHARS = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            substituted;
        logic            is_end;
    } t_result;

    typedef struct packed {
        logic    vld0;
        t_result res0;
        logic    vld1;
        t_result res1;
    } t_push;

    function automatic logic listed_surrogate(input logic [CP_W-1:0] v);
        return (v == SURR_D800) || (v == SURR_DB7F) || (v == SURR_DB80) ||
               (v == SURR_DBFF) || (v == SURR_DC00) || (v == SURR_DF80) ||
               (v == SURR_DFFF);
    endfunction

    function automatic logic value_ok(input logic [2:0] len, input logic [CP_W-1:0] v);
        logic ok;
        case (len)
            LEN_TWO:   ok = (v >= MIN_TWO) && (v <= MAX_TWO);
            LEN_THREE: ok = !listed_surrogate(v) && (v >= MIN_THREE) && (v <= MAX_THREE);
            LEN_FOUR:  ok = (v >= MIN_FOUR) && (v <= MAX_FOUR);
            default:   ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic t_result make_char(input logic [CP_W-1:0] cp, input logic bad,
                                          input logic ucs2);
        t_result r;
        logic    sub;
        sub          = bad || (ucs2 && (cp > MAX_BMP));
        r.code_point = sub ? SUB_CHAR : cp;
        r.substituted = sub;
        r.is_end     = 1'b0;
        return r;
    endfunction

endpackage
`default_nettype wire

@@ sv/utf8d_step.sv @@
// Sequence state and per-byte decode logic producing up to two results.
`default_nettype none
module utf8d_step (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic [7:0]                    i_text_byte,
    input  wire logic                          i_ucs2_mode,
    input  wire logic [utf8d_pkg::CNT_W-1:0]   i_max_chars,
    output utf8d_pkg::t_push                   o_push
);
    import utf8d_pkg::*;

    logic [2:0]       r_bytes_pending, n_bytes_pending;
    logic [2:0]       r_sequence_length, n_sequence_length;
    logic [CP_W-1:0]  r_partial_value, n_partial_value;
    logic [CNT_W-1:0] r_chars_emitted, n_chars_emitted;

    logic             cont;
    logic             open_seq;
    logic [CP_W-1:0]  shifted;
    logic [2:0]       pend_dec;
    logic [CNT_W-1:0] cnt_a;
    t_result          main_res;
    logic             main_char;
    t_push            push;

    assign cont     = (i_text_byte[7:6] == 2'b10);
    assign open_seq = (r_bytes_pending != 3'd0);
    assign shifted  = {r_partial_value[CP_W-7:0], i_text_byte[5:0]};
    assign pend_dec = r_bytes_pending - 3'd1;

    always_comb begin
        n_bytes_pending   = r_bytes_pending;
        n_sequence_length = r_sequence_length;
        n_partial_value   = r_partial_value;
        n_chars_emitted   = r_chars_emitted;
        push              = '0;
        main_res          = make_char(SUB_CHAR, 1'b1, i_ucs2_mode);
        main_char         = 1'b0;
        cnt_a             = r_chars_emitted;

        if (open_seq && cont) begin
            n_partial_value = shifted;
            n_bytes_pending = pend_dec;
            if (pend_dec == 3'd0) begin
                main_res  = make_char(shifted, !value_ok(r_sequence_length, shifted),
                                      i_ucs2_mode);
                main_char = 1'b1;
                n_bytes_pending   = 3'd0;
                n_sequence_length = 3'd0;
                n_partial_value   = '0;
            end
        end else begin
            if (open_seq) begin
                push.res0 = make_char(SUB_CHAR, 1'b1, i_ucs2_mode);
                if (r_chars_emitted < i_max_chars) begin
                    push.vld0 = 1'b1;
                    cnt_a     = r_chars_emitted + CNT_W'(1);
                end
                n_bytes_pending   = 3'd0;
                n_sequence_length = 3'd0;
                n_partial_value   = '0;
            end
            if (i_text_byte == 8'h00) begin
                push.vld1            = 1'b1;
                push.res1.code_point = '0;
                push.res1.substituted = 1'b0;
                push.res1.is_end     = 1'b1;
                n_bytes_pending   = 3'd0;
                n_sequence_length = 3'd0;
                n_partial_value   = '0;
            end else if (!i_text_byte[7]) begin
                main_res  = make_char({13'd0, i_text_byte}, 1'b0, i_ucs2_mode);
                main_char = 1'b1;
            end else if (!i_text_byte[6]) begin
                main_char = 1'b1;
            end else if (!i_text_byte[5]) begin
                n_sequence_length = LEN_TWO;
                n_bytes_pending   = LEN_TWO - 3'd1;
                n_partial_value   = {16'd0, i_text_byte[4:0]};
            end else if (!i_text_byte[4]) begin
                n_sequence_length = LEN_THREE;
                n_bytes_pending   = LEN_THREE - 3'd1;
                n_partial_value   = {17'd0, i_text_byte[3:0]};
            end else if (!i_text_byte[3]) begin
                n_sequence_length = LEN_FOUR;
                n_bytes_pending   = LEN_FOUR - 3'd1;
                n_partial_value   = {18'd0, i_text_byte[2:0]};
            end else if (!i_text_byte[2]) begin
                n_sequence_length = LEN_FIVE;
                n_bytes_pending   = LEN_FIVE - 3'd1;
                n_partial_value   = '0;
            end else begin
                n_sequence_length = LEN_SIX;
                n_bytes_pending   = LEN_SIX - 3'd1;
                n_partial_value   = '0;
            end
        end

        n_chars_emitted = cnt_a;
        if (main_char && (cnt_a < i_max_chars)) begin
            push.vld1       = 1'b1;
            push.res1       = main_res;
            n_chars_emitted = cnt_a + CNT_W'(1);
        end
        if (!(open_seq && cont) && (i_text_byte == 8'h00)) begin
            n_chars_emitted = '0;
        end

        if (!i_accept) begin
            push.vld0 = 1'b0;
            push.vld1 = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_pending   <= 3'd0;
            r_sequence_length <= 3'd0;
            r_partial_value   <= '0;
            r_chars_emitted   <= '0;
        end else if (i_accept) begin
            r_bytes_pending   <= n_bytes_pending;
            r_sequence_length <= n_sequence_length;
            r_partial_value   <= n_partial_value;
            r_chars_emitted   <= n_chars_emitted;
        end
    end

    assign o_push = push;

endmodule
`default_nettype wire

@@ sv/utf8d_res_queue.sv @@
// Result queue taking up to two results per cycle and handing out one beat per cycle unless stalled.
`default_nettype none
module utf8d_res_queue (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire utf8d_pkg::t_push              i_push,
    output logic                               o_full,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output utf8d_pkg::t_result                 o_res
);
    import utf8d_pkg::*;

    t_result              r_entry [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count, n_count;
    logic                 pop;
    logic [Q_PTR_W-1:0]   wr_second;

    assign pop       = o_valid && !i_stall;
    assign wr_second = r_wr_ptr + Q_PTR_W'(i_push.vld0);

    always_comb begin
        n_wr_ptr = r_wr_ptr + Q_PTR_W'(i_push.vld0) + Q_PTR_W'(i_push.vld1);
        n_rd_ptr = r_rd_ptr + Q_PTR_W'(pop);
        n_count  = r_count + Q_CNT_W'(i_push.vld0) + Q_CNT_W'(i_push.vld1)
                   - Q_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.vld0) begin
            r_entry[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.vld1) begin
            r_entry[wr_second] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Hold off input unless two free slots remain.
    assign o_full  = (r_count > Q_CNT_W'(Q_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_res   = r_entry[r_rd_ptr];

endmodule
`default_nettype wire

@@ sv/utf8_to_code_point_decoder_core.sv @@
// Top level of the UTF-8 to code point decoder.
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_stall    i_text_byte
//   out      output     o_out_valid / i_out_stall  o_code_point, o_substituted, o_is_end
//   cfg      input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// One byte per cycle is accepted while the queue has room; its results enter a four-entry
// result queue in the same edge and leave one beat per cycle unless the output stalls.
// A byte that yields two results puts two entries in the queue, which drain one at a time.
// Synchronous active-low reset clears sequence state, counter, queue and UCS-2 mode; max_chars goes to all ones.
// Input stalls while fewer than two queue slots are free; output stall only fills the queue.
`default_nettype none
module utf8_to_code_point_decoder_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [7:0]                        i_text_byte,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [utf8d_pkg::CP_W-1:0]             o_code_point,
    output logic                                   o_substituted,
    output logic                                   o_is_end,
    input  wire logic                              i_cfg_we,
    input  wire logic [utf8d_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [utf8d_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import utf8d_pkg::*;

    logic             r_ucs2_mode;
    logic [CNT_W-1:0] r_max_chars;
    logic             accept;
    logic             full;
    t_push            push;
    t_result          res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ucs2_mode <= 1'b0;
            r_max_chars <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_UCS2_MODE: r_ucs2_mode <= i_cfg_data[0];
                CFG_MAX_CHARS: r_max_chars <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign accept     = i_in_valid && !full;
    assign o_in_stall = full;

    utf8d_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_text_byte (i_text_byte),
        .i_ucs2_mode (r_ucs2_mode),
        .i_max_chars (r_max_chars),
        .o_push      (push)
    );

    utf8d_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (res)
    );

    assign o_code_point  = res.code_point;
    assign o_substituted = res.substituted;
    assign o_is_end      = res.is_end;

endmodule
`default_nettype wire
